/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DRGCM_CHECK(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("drgcm check failed");

`define DRGCM_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drgcm implication failed");

`define DRGCM_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drgcm next-cycle check failed");

`endif

/* hw/rtl/drgcm_pkg.sv */
package drgcm_pkg;

    localparam int CENTRE_HALF = 32;
    localparam int MAX_DIM     = 4096;

    localparam int COORD_W    = 12;
    localparam int REG_W      = 13;
    localparam int SHIFT_W    = 12;
    localparam int DEPTH_W    = 16;
    localparam int DIFF_W     = REG_W + 1;
    localparam int POS_W      = REG_W + 3;
    localparam int CNT_W      = $clog2(4 * CENTRE_HALF * CENTRE_HALF + 1);
    localparam int SUM_W      = DEPTH_W + CNT_W;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROI_LEFT   = 3'd0,
        CFG_ROI_TOP    = 3'd1,
        CFG_ROI_RIGHT  = 3'd2,
        CFG_ROI_BOTTOM = 3'd3,
        CFG_SHIFT_X    = 3'd4,
        CFG_SHIFT_Y    = 3'd5,
        CFG_NEAR_LIMIT = 3'd6,
        CFG_FAR_LIMIT  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic div_step;
    } cmd_t;

    typedef struct packed {
        logic item_done;
        logic div_last;
    } status_t;

endpackage

/* hw/rtl/drgcm_if.sv */
interface drgcm_in_if;
    import drgcm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DEPTH_W-1:0] depth_in;

    modport source (output valid, output depth_in, input ready);
    modport sink (input valid, input depth_in, output ready);
endinterface

interface drgcm_out_if;
    import drgcm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [COORD_W-1:0]        out_row;
    logic [COORD_W-1:0]        out_col;
    logic signed [DEPTH_W-1:0] out_depth;
    logic                      region_done;
    logic signed [DEPTH_W-1:0] centre_mean;

    modport source (output valid, output out_row, output out_col, output out_depth,
                    output region_done, output centre_mean, input ready);
    modport sink (input valid, input out_row, input out_col, input out_depth,
                  input region_done, input centre_mean, output ready);
endinterface

/* hw/rtl/drgcm_ctrl.sv */
module drgcm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  drgcm_pkg::status_t status,
    output drgcm_pkg::cmd_t    cmd
);
    import drgcm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.item_done ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.take     = 1'b0;
        cmd.div_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `include "assert_macros.svh"

    `DRGCM_CHECK(a_ready_valid_excl, !(in_ready && out_valid))
    `DRGCM_NEXT(a_done_goes_div, in_valid && in_ready && status.item_done, state_reg == ST_DIV)
    `DRGCM_NEXT(a_div_then_out, (state_reg == ST_DIV) && status.div_last, out_valid)

endmodule

/* hw/rtl/drgcm_dp.sv */
module drgcm_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [drgcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drgcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [drgcm_pkg::DEPTH_W-1:0] depth_in,
    input  drgcm_pkg::cmd_t                      cmd,
    output drgcm_pkg::status_t                   status,
    output logic [drgcm_pkg::COORD_W-1:0]        out_row,
    output logic [drgcm_pkg::COORD_W-1:0]        out_col,
    output logic signed [drgcm_pkg::DEPTH_W-1:0] out_depth,
    output logic                                 region_done,
    output logic signed [drgcm_pkg::DEPTH_W-1:0] centre_mean
);
    import drgcm_pkg::*;

    logic [REG_W-1:0]          left_reg;
    logic [REG_W-1:0]          top_reg;
    logic [REG_W-1:0]          right_reg;
    logic [REG_W-1:0]          bottom_reg;
    logic [SHIFT_W-1:0]        shift_x_reg;
    logic [SHIFT_W-1:0]        shift_y_reg;
    logic signed [DEPTH_W-1:0] near_reg;
    logic signed [DEPTH_W-1:0] far_reg;

    logic [COORD_W-1:0]        col_cnt_reg;
    logic [COORD_W-1:0]        col_cnt_next;
    logic [COORD_W-1:0]        row_cnt_reg;
    logic [COORD_W-1:0]        row_cnt_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;

    logic [SUM_W-1:0]          dvd_reg;
    logic [SUM_W-1:0]          dvd_next;
    logic [CNT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          rem_next;
    logic [CNT_W-1:0]          dvs_reg;
    logic                      neg_reg;
    logic [STEP_W-1:0]         step_reg;

    logic [COORD_W-1:0]        row_reg;
    logic [COORD_W-1:0]        col_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic                      done_reg;
    logic signed [DEPTH_W-1:0] mean_reg;
    logic signed [DEPTH_W-1:0] mean_next;

    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]         col_lim;
    logic [DIFF_W-1:0]         row_lim;
    logic signed [DIFF_W-1:0]  hx;
    logic signed [DIFF_W-1:0]  hy;
    logic signed [POS_W-1:0]   cl;
    logic signed [POS_W-1:0]   ct;
    logic signed [POS_W-1:0]   col_pos;
    logic signed [POS_W-1:0]   row_pos;
    logic                      last_col;
    logic                      last_row;
    logic                      item_done;
    logic                      in_band;
    logic                      in_centre;
    logic [SUM_W-1:0]          sum_mag;
    logic [CNT_W:0]            rem_sh;
    logic                      fits;
    logic [SUM_W-1:0]          quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg    <= '0;
            top_reg     <= '0;
            right_reg   <= REG_W'(640);
            bottom_reg  <= REG_W'(480);
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            near_reg    <= '0;
            far_reg     <= DEPTH_W'(32767);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROI_LEFT:   left_reg    <= cfg_data[REG_W-1:0];
                CFG_ROI_TOP:    top_reg     <= cfg_data[REG_W-1:0];
                CFG_ROI_RIGHT:  right_reg   <= cfg_data[REG_W-1:0];
                CFG_ROI_BOTTOM: bottom_reg  <= cfg_data[REG_W-1:0];
                CFG_SHIFT_X:    shift_x_reg <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Y:    shift_y_reg <= cfg_data[SHIFT_W-1:0];
                CFG_NEAR_LIMIT: near_reg    <= $signed(cfg_data[DEPTH_W-1:0]);
                CFG_FAR_LIMIT:  far_reg     <= $signed(cfg_data[DEPTH_W-1:0]);
                default:        left_reg    <= left_reg;
            endcase
        end
    end

    always_comb
    begin
        dx = $signed({1'b0, right_reg}) - $signed({1'b0, left_reg});
        dy = $signed({1'b0, bottom_reg}) - $signed({1'b0, top_reg});

        if (dx < $signed(DIFF_W'(1)))
        begin
            col_lim = '0;
        end
        else if (dx > $signed(DIFF_W'(MAX_DIM)))
        begin
            col_lim = DIFF_W'(MAX_DIM - 1);
        end
        else
        begin
            col_lim = DIFF_W'(dx - $signed(DIFF_W'(1)));
        end

        if (dy < $signed(DIFF_W'(1)))
        begin
            row_lim = '0;
        end
        else if (dy > $signed(DIFF_W'(MAX_DIM)))
        begin
            row_lim = DIFF_W'(MAX_DIM - 1);
        end
        else
        begin
            row_lim = DIFF_W'(dy - $signed(DIFF_W'(1)));
        end

        last_col  = {{(DIFF_W-COORD_W){1'b0}}, col_cnt_reg} >= col_lim;
        last_row  = {{(DIFF_W-COORD_W){1'b0}}, row_cnt_reg} >= row_lim;
        item_done = last_col && last_row;

        hx = (dx + $signed({{(DIFF_W-1){1'b0}}, dx[DIFF_W-1]})) >>> 1;
        hy = (dy + $signed({{(DIFF_W-1){1'b0}}, dy[DIFF_W-1]})) >>> 1;

        cl = $signed({{(POS_W-REG_W){1'b0}}, left_reg})
             + $signed({{(POS_W-DIFF_W){hx[DIFF_W-1]}}, hx})
             + $signed({{(POS_W-SHIFT_W){shift_x_reg[SHIFT_W-1]}}, shift_x_reg})
             - $signed(POS_W'(CENTRE_HALF));
        ct = $signed({{(POS_W-REG_W){1'b0}}, top_reg})
             + $signed({{(POS_W-DIFF_W){hy[DIFF_W-1]}}, hy})
             + $signed({{(POS_W-SHIFT_W){shift_y_reg[SHIFT_W-1]}}, shift_y_reg})
             - $signed(POS_W'(CENTRE_HALF));

        col_pos = $signed({{(POS_W-REG_W){1'b0}}, left_reg}
                          + {{(POS_W-COORD_W){1'b0}}, col_cnt_reg});
        row_pos = $signed({{(POS_W-REG_W){1'b0}}, top_reg}
                          + {{(POS_W-COORD_W){1'b0}}, row_cnt_reg});

        in_band   = (depth_in >= near_reg) && (depth_in <= far_reg);
        in_centre = (col_pos >= cl) && (col_pos < cl + $signed(POS_W'(2 * CENTRE_HALF)))
                    && (row_pos >= ct)
                    && (row_pos < ct + $signed(POS_W'(2 * CENTRE_HALF)));

        if (in_band && in_centre)
        begin
            sum_next = sum_reg + $signed({{(SUM_W-DEPTH_W){depth_in[DEPTH_W-1]}}, depth_in});
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            sum_next = sum_reg;
            cnt_next = cnt_reg;
        end

        if (item_done)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_cnt_reg + COORD_W'(1);
        end
        else
        begin
            col_cnt_next = col_cnt_reg + COORD_W'(1);
            row_cnt_next = row_cnt_reg;
        end

        sum_mag = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

        rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
        fits     = rem_sh >= {1'b0, dvs_reg};
        rem_next = fits ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
        dvd_next = {dvd_reg[SUM_W-2:0], fits};
        quo      = neg_reg ? SUM_W'(-dvd_next) : dvd_next;
        mean_next = (dvs_reg == '0) ? '0 : $signed(quo[DEPTH_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            step_reg    <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            depth_reg   <= '0;
            done_reg    <= 1'b0;
            mean_reg    <= '0;
        end
        else if (cmd.take)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            sum_reg     <= item_done ? '0 : sum_next;
            cnt_reg     <= item_done ? '0 : cnt_next;
            step_reg    <= STEP_W'(SUM_W - 1);
            row_reg     <= row_pos[COORD_W-1:0];
            col_reg     <= col_pos[COORD_W-1:0];
            depth_reg   <= in_band ? depth_in : '0;
            done_reg    <= item_done;
            mean_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                mean_reg <= mean_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            dvd_reg <= sum_mag;
            rem_reg <= '0;
            dvs_reg <= cnt_next;
            neg_reg <= sum_next[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign status.item_done = item_done;
    assign status.div_last  = (step_reg == '0);

    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign out_depth   = depth_reg;
    assign region_done = done_reg;
    assign centre_mean = mean_reg;

    `include "assert_macros.svh"

    `DRGCM_IMPLY(a_mean_zero_mid, !done_reg, mean_reg == '0)
    `DRGCM_NEXT(a_region_clears, cmd.take && item_done, (cnt_reg == '0) && (col_cnt_reg == '0))
    `DRGCM_NEXT(a_row_advances, cmd.take && last_col && !last_row, col_cnt_reg == '0)

endmodule

/* hw/rtl/depth_roi_gate_center_mean.sv */
// Depth region-of-interest gate with centre-square mean.
// Depth pixels of one region arrive on in_ch in raster order, one per transaction.
// Each accepted pixel yields one transaction on out_ch carrying its destination
// row and column, the depth gated to the near..far band (zero outside it), a flag
// on the region's last pixel and, with that flag, the truncated signed mean of the
// in-band pixels inside the centre square (zero when there were none).
// Configuration is to be written by the user through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block does not enforce this. Registers follow
// the documented index order. One pixel is held at a time. A pixel is accepted in
// one cycle and, unless it is the region's last, its result is presented in the
// next. The region's last pixel first passes through the bit-serial divider that
// forms the mean, one quotient bit per cycle.
// While a result waits on out_ch, in_ch.ready stays low and the result holds.
// Reset loads the register defaults (region 640 by 480 at the origin, band 0 to
// 32767, no shift) and clears the row and column counters and the accumulators.
module depth_roi_gate_center_mean (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [drgcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drgcm_pkg::CFG_DATA_W-1:0] cfg_data,
    drgcm_in_if.sink                         in_ch,
    drgcm_out_if.source                      out_ch
);
    import drgcm_pkg::*;

    cmd_t    cmd;
    status_t status;

    drgcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    drgcm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .depth_in    (in_ch.depth_in),
        .cmd         (cmd),
        .status      (status),
        .out_row     (out_ch.out_row),
        .out_col     (out_ch.out_col),
        .out_depth   (out_ch.out_depth),
        .region_done (out_ch.region_done),
        .centre_mean (out_ch.centre_mean)
    );

endmodule

/* bench/roi_mean_checker.sv */
module roi_mean_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [drgcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drgcm_pkg::CFG_DATA_W-1:0] cfg_data,
    drgcm_in_if                              in_ch,
    drgcm_out_if                             out_ch,
    output int                               fails,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import drgcm_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [DEPTH_W-1:0] depth;
        logic                      done;
        logic signed [DEPTH_W-1:0] mean;
    } pixel_result_t;

    logic [REG_W-1:0]          roi_left;
    logic [REG_W-1:0]          roi_top;
    logic [REG_W-1:0]          roi_right;
    logic [REG_W-1:0]          roi_bottom;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [DEPTH_W-1:0] near_limit;
    logic signed [DEPTH_W-1:0] far_limit;
    logic [COORD_W-1:0]        col_cnt;
    logic [COORD_W-1:0]        row_cnt;
    longint                    centre_sum;
    int                        centre_cnt;
    pixel_result_t             expected_pixels[$];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic longint clamp_span(input longint lo, input longint hi);
        longint d;
        d = hi - lo;
        if (d < 1)
        begin
            d = 1;
        end
        if (d > MAX_DIM)
        begin
            d = MAX_DIM;
        end
        return d;
    endfunction

    function automatic pixel_result_t gate_pixel(input logic signed [DEPTH_W-1:0] depth);
        pixel_result_t res;
        longint        w;
        longint        h;
        longint        col;
        longint        row;
        longint        cl;
        longint        ct;
        logic          last_col;
        w   = clamp_span(longint'(roi_left), longint'(roi_right));
        h   = clamp_span(longint'(roi_top), longint'(roi_bottom));
        col = longint'(roi_left) + longint'(col_cnt);
        row = longint'(roi_top) + longint'(row_cnt);
        cl  = longint'(roi_left) + (longint'(roi_right) - longint'(roi_left)) / 2
              + longint'(shift_x) - CENTRE_HALF;
        ct  = longint'(roi_top) + (longint'(roi_bottom) - longint'(roi_top)) / 2
              + longint'(shift_y) - CENTRE_HALF;
        res = '0;
        res.row = row[COORD_W-1:0];
        res.col = col[COORD_W-1:0];
        last_col = longint'(col_cnt) >= w - 1;
        res.done = last_col && (longint'(row_cnt) >= h - 1);
        if (depth >= near_limit && depth <= far_limit)
        begin
            res.depth = depth;
            if (row >= ct && row < ct + 2 * CENTRE_HALF && col >= cl && col < cl + 2 * CENTRE_HALF)
            begin
                centre_sum += longint'(depth);
                centre_cnt++;
            end
        end
        if (res.done)
        begin
            if (centre_cnt != 0)
            begin
                res.mean = DEPTH_W'(centre_sum / longint'(centre_cnt));
            end
            col_cnt    = '0;
            row_cnt    = '0;
            centre_sum = 0;
            centre_cnt = 0;
        end
        else if (last_col)
        begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            roi_left   = '0;
            roi_top    = '0;
            roi_right  = 13'd640;
            roi_bottom = 13'd480;
            shift_x    = '0;
            shift_y    = '0;
            near_limit = '0;
            far_limit  = 16'sh7FFF;
            col_cnt    = '0;
            row_cnt    = '0;
            centre_sum = 0;
            centre_cnt = 0;
            expected_pixels.delete();
            fails       = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction at row %0d col %0d",
                                              out_ch.out_row, out_ch.out_col));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("out_row", longint'(out_ch.out_row), longint'(want.row));
                    compare_field("out_col", longint'(out_ch.out_col), longint'(want.col));
                    compare_field("out_depth", longint'(out_ch.out_depth), longint'(want.depth));
                    compare_field("region_done", longint'(out_ch.region_done),
                                  longint'(want.done));
                    compare_field("centre_mean", longint'(out_ch.centre_mean),
                                  longint'(want.mean));
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROI_LEFT:   roi_left   = cfg_data[REG_W-1:0];
                    CFG_ROI_TOP:    roi_top    = cfg_data[REG_W-1:0];
                    CFG_ROI_RIGHT:  roi_right  = cfg_data[REG_W-1:0];
                    CFG_ROI_BOTTOM: roi_bottom = cfg_data[REG_W-1:0];
                    CFG_SHIFT_X:    shift_x    = cfg_data[SHIFT_W-1:0];
                    CFG_SHIFT_Y:    shift_y    = cfg_data[SHIFT_W-1:0];
                    CFG_NEAR_LIMIT: near_limit = cfg_data[DEPTH_W-1:0];
                    CFG_FAR_LIMIT:  far_limit  = cfg_data[DEPTH_W-1:0];
                    default:        ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_pixels.push_back(gate_pixel(in_ch.depth_in));
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import drgcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 850;
    localparam int REG_MAX        = 4096;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [CFG_DATA_W-1:0] reg_val [8];
    int                    fails;
    int                    outstanding;
    int                    idle_pct;
    int                    stall_pct;
    int                    quiet_cycles = 0;
    int                    sent;

    drgcm_in_if  in_ch();
    drgcm_out_if out_ch();

    depth_roi_gate_center_mean dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    roi_mean_checker roi_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("depth_roi_gate_center_mean test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.depth_in <= depth;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_regs();
        cfg_idx_t idx;
        idx = idx.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_val[idx];
            @(negedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_origin();
        int r;
        r = $urandom_range(9);
        if (r < 7)
        begin
            return CFG_DATA_W'($urandom_range(64));
        end
        else if (r == 7)
        begin
            return CFG_DATA_W'(REG_MAX);
        end
        else if (r == 8)
        begin
            return CFG_DATA_W'($urandom_range(REG_MAX, REG_MAX - 16));
        end
        return CFG_DATA_W'($urandom_range(REG_MAX));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_end(input logic [CFG_DATA_W-1:0] lo);
        int r;
        int e;
        r = $urandom_range(9);
        if (r < 7)
        begin
            e = int'(lo) + $urandom_range(1, 10);
        end
        else if (r == 7)
        begin
            e = int'(lo);
        end
        else if (r == 8)
        begin
            e = $urandom_range(int'(lo));
        end
        else
        begin
            e = $urandom_range(REG_MAX);
        end
        if (e > REG_MAX)
        begin
            e = REG_MAX;
        end
        return CFG_DATA_W'(e);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_shift();
        int                 r;
        logic [SHIFT_W-1:0] s;
        r = $urandom_range(9);
        if (r < 6)
        begin
            s = SHIFT_W'($urandom_range(80) - 40);
        end
        else if (r < 8)
        begin
            s = SHIFT_W'($urandom);
        end
        else
        begin
            s = $urandom_range(1) ? 12'h800 : 12'h7FF;
        end
        return {{(CFG_DATA_W - SHIFT_W){s[SHIFT_W-1]}}, s};
    endfunction

    task automatic rand_config();
        int r;
        reg_val[CFG_ROI_LEFT]   = pick_origin();
        reg_val[CFG_ROI_TOP]    = pick_origin();
        reg_val[CFG_ROI_RIGHT]  = pick_end(reg_val[CFG_ROI_LEFT]);
        reg_val[CFG_ROI_BOTTOM] = pick_end(reg_val[CFG_ROI_TOP]);
        reg_val[CFG_SHIFT_X]    = pick_shift();
        reg_val[CFG_SHIFT_Y]    = pick_shift();
        r = $urandom_range(9);
        if (r < 6)
        begin
            reg_val[CFG_NEAR_LIMIT] = CFG_DATA_W'(-$urandom_range(3000));
            reg_val[CFG_FAR_LIMIT]  = CFG_DATA_W'($urandom_range(3000));
        end
        else if (r == 6)
        begin
            reg_val[CFG_NEAR_LIMIT] = CFG_DATA_W'($urandom_range(3000, 1));
            reg_val[CFG_FAR_LIMIT]  = CFG_DATA_W'(-$urandom_range(3000));
        end
        else if (r == 7)
        begin
            reg_val[CFG_NEAR_LIMIT] = CFG_DATA_W'($urandom);
            reg_val[CFG_FAR_LIMIT]  = CFG_DATA_W'($urandom);
        end
        else if (r == 8)
        begin
            reg_val[CFG_NEAR_LIMIT] = 16'h8000;
            reg_val[CFG_FAR_LIMIT]  = 16'h7FFF;
        end
        else
        begin
            reg_val[CFG_NEAR_LIMIT] = CFG_DATA_W'($urandom_range(200) - 100);
            reg_val[CFG_FAR_LIMIT]  = reg_val[CFG_NEAR_LIMIT];
        end
    endtask

    function automatic logic [DEPTH_W-1:0] pick_depth();
        int r;
        r = $urandom_range(9);
        if (r < 4)
        begin
            return DEPTH_W'($urandom);
        end
        else if (r == 4)
        begin
            return reg_val[CFG_NEAR_LIMIT] + DEPTH_W'($urandom_range(4) - 2);
        end
        else if (r == 5)
        begin
            return reg_val[CFG_FAR_LIMIT] + DEPTH_W'($urandom_range(4) - 2);
        end
        else if (r == 6)
        begin
            return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        return DEPTH_W'($urandom_range(4000) - 2000);
    endfunction

    function automatic int region_pixels();
        int w;
        int h;
        w = int'(reg_val[CFG_ROI_RIGHT]) - int'(reg_val[CFG_ROI_LEFT]);
        h = int'(reg_val[CFG_ROI_BOTTOM]) - int'(reg_val[CFG_ROI_TOP]);
        w = (w < 1) ? 1 : w;
        h = (h < 1) ? 1 : h;
        return w * h;
    endfunction

    initial
    begin
        int idle_mode [4];
        int stall_mode [4];
        int mode_sent;
        int n;
        idle_mode  = '{0, 65, 0, 33};
        stall_mode = '{0, 0, 65, 33};
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ROI_LEFT;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.depth_in = '0;
        out_ch.ready   = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        sent           = 0;
        reg_val[CFG_ROI_LEFT]   = 16'd0;
        reg_val[CFG_ROI_TOP]    = 16'd0;
        reg_val[CFG_ROI_RIGHT]  = 16'd640;
        reg_val[CFG_ROI_BOTTOM] = 16'd480;
        reg_val[CFG_SHIFT_X]    = 16'd0;
        reg_val[CFG_SHIFT_Y]    = 16'd0;
        reg_val[CFG_NEAR_LIMIT] = 16'd0;
        reg_val[CFG_FAR_LIMIT]  = 16'h7FFF;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_pixel(16'h7FFF);
        send_pixel(16'h8000);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);

        // The region shrinks to one pixel at the top of the coordinate range while
        // the counters are mid-row, and both coordinates wrap.
        wait_idle();
        reg_val[CFG_ROI_LEFT]   = 16'd4096;
        reg_val[CFG_ROI_TOP]    = 16'd4096;
        reg_val[CFG_ROI_RIGHT]  = 16'd4096;
        reg_val[CFG_ROI_BOTTOM] = 16'd0;
        reg_val[CFG_NEAR_LIMIT] = 16'h8000;
        reg_val[CFG_FAR_LIMIT]  = 16'h7FFF;
        write_regs();
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);

        wait_idle();
        reg_val[CFG_SHIFT_Y] = 16'h07FF;
        write_regs();
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(-16'sd5);

        wait_idle();
        reg_val[CFG_ROI_LEFT]   = 16'd10;
        reg_val[CFG_ROI_RIGHT]  = 16'd12;
        reg_val[CFG_ROI_TOP]    = 16'd20;
        reg_val[CFG_ROI_BOTTOM] = 16'd21;
        reg_val[CFG_SHIFT_Y]    = 16'd0;
        write_regs();
        send_pixel(-16'sd3);
        send_pixel(-16'sd4);
        send_pixel(16'sd3);
        send_pixel(16'sd4);
        send_pixel(16'sd7);
        send_pixel(-16'sd100);

        wait_idle();
        reg_val[CFG_NEAR_LIMIT] = 16'd100;
        reg_val[CFG_FAR_LIMIT]  = -16'sd100;
        write_regs();
        send_pixel(16'sd0);
        send_pixel(16'sd50);

        wait_idle();
        reg_val[CFG_ROI_BOTTOM] = 16'd22;
        reg_val[CFG_NEAR_LIMIT] = -16'sd10;
        reg_val[CFG_FAR_LIMIT]  = 16'sd10;
        write_regs();
        send_pixel(-16'sd10);
        send_pixel(16'sd10);
        send_pixel(-16'sd11);
        send_pixel(16'sd9);

        wait_idle();
        reg_val[CFG_ROI_LEFT]   = 16'd0;
        reg_val[CFG_ROI_TOP]    = 16'd0;
        reg_val[CFG_ROI_RIGHT]  = 16'd4096;
        reg_val[CFG_ROI_BOTTOM] = 16'd4096;
        reg_val[CFG_SHIFT_X]    = 16'hF800;
        reg_val[CFG_SHIFT_Y]    = 16'h07FF;
        reg_val[CFG_NEAR_LIMIT] = 16'h8000;
        reg_val[CFG_FAR_LIMIT]  = 16'h7FFF;
        write_regs();
        repeat (3) send_pixel(pick_depth());

        for (int m = 0; m < 4; m++)
        begin
            idle_pct  = idle_mode[m];
            stall_pct = stall_mode[m];
            mode_sent = 0;
            while (mode_sent < RANDOM_ITEMS / 4)
            begin
                rand_config();
                wait_idle();
                write_regs();
                n = region_pixels() * $urandom_range(2, 1);
                if ($urandom_range(3) == 0)
                begin
                    n += $urandom_range(region_pixels() - 1);
                end
                if (n > 60)
                begin
                    n = 60;
                end
                repeat (n) send_pixel(pick_depth());
                mode_sent += n;
            end
        end

        wait_idle();
        repeat (40) @(negedge clk);
        if (fails == 0 && outstanding == 0)
        begin
            $display("depth_roi_gate_center_mean test passed");
        end
        else
        begin
            $display("depth_roi_gate_center_mean test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/drgcm_pkg.sv
hw/rtl/drgcm_if.sv
hw/rtl/drgcm_ctrl.sv
hw/rtl/drgcm_dp.sv
hw/rtl/depth_roi_gate_center_mean.sv
bench/roi_mean_checker.sv
bench/testbench.sv
